FILE: design/rpq_pkg.sv
// Shared types and constants for the range presence qualifier.
package rpq_pkg;

    // Field widths of one ranging sample and of the configuration registers.
    localparam int DIST_W   = 16;
    localparam int STATUS_W = 8;
    localparam int TIME_W   = 32;
    localparam int HOLD_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME    = 1'd1;

    // Register values after reset.
    localparam logic [DIST_W-1:0] MAX_DISTANCE_RST = 16'd1000;
    localparam logic [HOLD_W-1:0] HOLD_TIME_RST    = 16'd2000;

    // Sensor range status codes.
    localparam logic [STATUS_W-1:0] STATUS_VALID     = 8'd0;
    localparam logic [STATUS_W-1:0] STATUS_SIGMA_BAD = 8'd4;
    localparam logic [STATUS_W-1:0] STATUS_NO_TARGET = 8'd12;

    // One accepted ranging sample.
    typedef struct packed {
        logic [DIST_W-1:0]   distance;
        logic [STATUS_W-1:0] zone_status;
        logic [TIME_W-1:0]   now_ms;
        logic                was_present;
    } t_sample;

    // One qualified decision.
    typedef struct packed {
        logic present;
        logic stuck;
    } t_decision;

endpackage

FILE: design/rpq_if.sv
// Valid/ready channel interfaces for ranging samples and decisions.
interface rpq_sample_if;
    logic                       valid;
    logic                       ready;
    logic [rpq_pkg::DIST_W-1:0]   distance;
    logic [rpq_pkg::STATUS_W-1:0] zone_status;
    logic [rpq_pkg::TIME_W-1:0]   now_ms;
    logic                       was_present;

    modport source (output valid, distance, zone_status, now_ms, was_present, input ready);
    modport sink   (input valid, distance, zone_status, now_ms, was_present, output ready);
endinterface

interface rpq_decision_if;
    logic valid;
    logic ready;
    logic present;
    logic stuck;

    modport source (output valid, present, stuck, input ready);
    modport sink   (input valid, present, stuck, output ready);
endinterface

FILE: design/rpq_ring.sv
// Ring of recent distances and the all-equal (stuck) test.
module rpq_ring #(
    parameter int STUCK_DEPTH = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  logic [rpq_pkg::DIST_W-1:0] i_distance,
    output logic                       o_stuck
);
    import rpq_pkg::*;

    localparam int SLOT_W = $clog2(STUCK_DEPTH);

    logic [DIST_W-1:0] r_ring [STUCK_DEPTH];
    logic [DIST_W-1:0] n_ring [STUCK_DEPTH];
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;

    // Ring contents after this transaction's write, and the stuck test on them.
    always_comb begin
        for (int k = 0; k < STUCK_DEPTH; k++) begin
            n_ring[k] = (r_slot == SLOT_W'(k)) ? i_distance : r_ring[k];
        end
        o_stuck = 1'b1;
        for (int k = 1; k < STUCK_DEPTH; k++) begin
            if (n_ring[k] != n_ring[0]) begin
                o_stuck = 1'b0;
            end
        end
        n_slot = (r_slot == SLOT_W'(STUCK_DEPTH - 1)) ? '0 : r_slot + 1'b1;
    end

    // The ring starts all zero, so a run of zero distances reads as stuck.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STUCK_DEPTH; k++) begin
                r_ring[k] <= '0;
            end
            r_slot <= '0;
        end else if (i_advance) begin
            r_ring <= n_ring;
            r_slot <= n_slot;
        end
    end

endmodule

FILE: design/rpq_timer.sv
// Presence and absence qualification with the hold timer.
module rpq_timer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  rpq_pkg::t_sample           i_sample,
    input  logic                       i_stuck,
    input  logic [rpq_pkg::DIST_W-1:0] i_max_distance,
    input  logic [rpq_pkg::HOLD_W-1:0] i_hold_time,
    output rpq_pkg::t_decision         o_decision
);
    import rpq_pkg::*;

    logic              r_armed;
    logic [TIME_W-1:0] r_start;
    logic              n_armed;
    logic [TIME_W-1:0] n_start;
    logic              w_arrive;
    logic              w_leave;
    logic              w_qual;
    logic              w_fire;
    logic [TIME_W-1:0] w_elapsed;

    // Qualifying condition for the current decision, then the hold test.
    always_comb begin
        w_arrive = (i_sample.distance <= i_max_distance)
                && (i_sample.zone_status == STATUS_VALID) && !i_stuck;
        w_leave  = (i_sample.distance >= i_max_distance)
                || (i_sample.zone_status inside {STATUS_SIGMA_BAD, STATUS_NO_TARGET})
                || i_stuck;
        w_qual   = i_sample.was_present ? w_leave : w_arrive;

        // A first qualifying sample starts the timer at its own time stamp.
        n_start   = r_armed ? r_start : i_sample.now_ms;
        w_elapsed = i_sample.now_ms - n_start;
        w_fire    = w_qual && (w_elapsed >= TIME_W'(i_hold_time));
        n_armed   = w_qual && !w_fire;

        o_decision.present = w_fire ? !i_sample.was_present : i_sample.was_present;
        o_decision.stuck   = i_stuck;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_start <= '0;
        end else if (i_advance) begin
            r_armed <= n_armed;
            r_start <= n_start;
        end
    end

    // The decision only changes when the sample qualifies.
    a_flip_needs_qual: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && (o_decision.present != i_sample.was_present) |-> w_qual)
        else $error("decision changed without a qualifying sample");

    // Firing disarms the timer.
    a_fire_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && w_fire |=> !r_armed)
        else $error("timer still armed after firing");

endmodule

FILE: design/range_presence_qualifier_core.sv
// Range presence qualifier: top level with channel registers and configuration.
//
// Ranging samples arrive on i_sample (distance, zone status, millisecond time
// stamp and the caller's previous decision); one decision per sample leaves
// on o_result (present, stuck). Both channels are valid/ready.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 max_distance, 1 hold_time_ms); write only while no transaction is open.
// A sample lands in the input register at acceptance, and its decision is
// registered in the result register as it moves on. Throughput is one sample
// per cycle while o_result is ready; the ring compare and the hold-time
// subtract/compare sit between the input register and the result register, and
// ring and timer state update as each sample moves across.
// Reset clears the distance ring to zero, disarms the timer, loads the
// register defaults (1000 mm, 2000 ms) and empties both channel registers.
// When the receiver stalls the decision is held; the input register still
// takes one more sample if it was empty, after which i_sample.ready drops
// until o_result drains.
module range_presence_qualifier_core #(
    parameter int STUCK_DEPTH = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rpq_sample_if.sink                    i_sample,
    rpq_decision_if.source                o_result,
    input  logic                          i_cfg_we,
    input  logic [rpq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rpq_pkg::CFG_W-1:0]     i_cfg_data
);
    import rpq_pkg::*;

    logic              r_in_valid;
    t_sample           r_in;
    logic              r_out_valid;
    t_decision         r_out;
    logic [DIST_W-1:0] r_max_distance;
    logic [HOLD_W-1:0] r_hold_time;
    logic              w_advance;
    logic              w_stuck;
    t_decision         w_decision;

    // A sample moves on when the result register is empty or being emptied.
    assign w_advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_sample.ready = !r_in_valid || w_advance;
    assign o_result.valid   = r_out_valid;
    assign o_result.present = r_out.present;
    assign o_result.stuck   = r_out.stuck;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_distance <= MAX_DISTANCE_RST;
            r_hold_time    <= HOLD_TIME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_DISTANCE: r_max_distance <= DIST_W'(i_cfg_data);
                CFG_HOLD_TIME:    r_hold_time    <= HOLD_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_in.distance    <= i_sample.distance;
            r_in.zone_status <= i_sample.zone_status;
            r_in.now_ms      <= i_sample.now_ms;
            r_in.was_present <= i_sample.was_present;
        end
    end

    rpq_ring #(
        .STUCK_DEPTH (STUCK_DEPTH)
    ) u_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (w_advance),
        .i_distance (r_in.distance),
        .o_stuck    (w_stuck)
    );

    rpq_timer u_timer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (w_advance),
        .i_sample       (r_in),
        .i_stuck        (w_stuck),
        .i_max_distance (r_max_distance),
        .i_hold_time    (r_hold_time),
        .o_decision     (w_decision)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_decision;
        end
    end

    // An empty input register always takes a sample.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_sample.ready)
        else $error("input stalled while the input register is empty");

    // A sample that moves on always produces a result.
    a_advance_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("result lost after a sample moved on");

    // A held sample is not dropped.
    a_hold_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid)
        else $error("stalled sample dropped");

endmodule

FILE: sim/tb_range_presence_qualifier_core.sv
// Self-checking testbench for the range presence qualifier core.
`timescale 1ns / 1ps

module tb_range_presence_qualifier_core;
    import rpq_pkg::*;

    localparam int RING_DEPTH     = 10;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 165;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    rpq_sample_if   smp_if ();
    rpq_decision_if dec_if ();

    range_presence_qualifier_core #(
        .STUCK_DEPTH (RING_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (smp_if),
        .o_result   (dec_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Shadow of the qualifier state and its registers.
    logic [DIST_W-1:0] shadow_ring [RING_DEPTH];
    logic [3:0]        shadow_slot;
    logic              shadow_armed;
    logic [TIME_W-1:0] shadow_start;
    logic [DIST_W-1:0] shadow_max_dist;
    logic [HOLD_W-1:0] shadow_hold;

    // Decisions still owed by the block, oldest first.
    t_decision pending_decisions [$];

    int mismatch_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_left;

    // Stimulus generator state.
    logic              caller_present;
    logic              near_scene;
    logic [TIME_W-1:0] tick_ms;
    int                repeat_left;
    logic [DIST_W-1:0] repeat_dist;

    // The clock toggles every 2 ns for a 4 ns period.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Runs the hold timer, arming it on first use; true once the hold time has passed.
    function automatic logic hold_elapsed(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] waited;
        if (!shadow_armed) begin
            shadow_armed = 1'b1;
            shadow_start = now;
        end
        waited = now - shadow_start;
        if (waited >= TIME_W'(shadow_hold)) begin
            shadow_armed = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Works out the decision for one sample and advances the shadow state.
    function automatic t_decision qualify(input t_sample s);
        t_decision d;
        logic      all_same;
        logic      arrive;
        logic      leave;
        if (shadow_slot >= RING_DEPTH) shadow_slot = '0;
        shadow_ring[shadow_slot] = s.distance;
        shadow_slot = shadow_slot + 4'd1;
        if (shadow_slot >= RING_DEPTH) shadow_slot = '0;

        all_same = 1'b1;
        for (int k = 1; k < RING_DEPTH; k++) begin
            if (shadow_ring[k] != shadow_ring[0]) all_same = 1'b0;
        end

        d.present = s.was_present;
        d.stuck   = all_same;
        if (!s.was_present) begin
            arrive = (s.distance <= shadow_max_dist) && (s.zone_status == STATUS_VALID)
                     && !all_same;
            if (!arrive) shadow_armed = 1'b0;
            else if (hold_elapsed(s.now_ms)) d.present = 1'b1;
        end else begin
            leave = (s.distance >= shadow_max_dist) || (s.zone_status == STATUS_SIGMA_BAD)
                    || (s.zone_status == STATUS_NO_TARGET) || all_same;
            if (!leave) shadow_armed = 1'b0;
            else if (hold_elapsed(s.now_ms)) d.present = 1'b0;
        end
        return d;
    endfunction

    function automatic t_sample mk(input logic [DIST_W-1:0] range_mm,
                                   input logic [STATUS_W-1:0] st,
                                   input logic [TIME_W-1:0] now, input logic was);
        t_sample s;
        s.distance    = range_mm;
        s.zone_status = st;
        s.now_ms      = now;
        s.was_present = was;
        return s;
    endfunction

    // Builds a plausible sample stream: a scene that is near or far for a while, a
    // steadily advancing tick, runs of equal distances and some pure noise.
    function automatic t_sample next_sample();
        t_sample           s;
        logic [DIST_W-1:0] d;
        int                pick;
        if ($urandom_range(0, 99) < 12) begin
            s.distance    = DIST_W'($urandom);
            s.zone_status = STATUS_W'($urandom);
            s.now_ms      = $urandom;
            s.was_present = 1'($urandom);
            return s;
        end
        if ($urandom_range(0, 11) == 0) near_scene = !near_scene;

        if (near_scene) begin
            d = ($urandom_range(0, 7) == 0) ? shadow_max_dist
                                            : DIST_W'($urandom_range(0, shadow_max_dist));
        end else begin
            d = ($urandom_range(0, 7) == 0) ? shadow_max_dist
                                            : DIST_W'($urandom_range(shadow_max_dist, 16'hFFFF));
        end
        if (repeat_left > 0) begin
            d = repeat_dist;
            repeat_left--;
        end else if ($urandom_range(0, 39) == 0) begin
            repeat_left = $urandom_range(8, 13);
            repeat_dist = d;
        end
        s.distance = d;

        pick = $urandom_range(0, 99);
        if (pick < (near_scene ? 85 : 40))      s.zone_status = STATUS_VALID;
        else if (pick < (near_scene ? 90 : 65)) s.zone_status = STATUS_SIGMA_BAD;
        else if (pick < (near_scene ? 95 : 90)) s.zone_status = STATUS_NO_TARGET;
        else                                    s.zone_status = STATUS_W'($urandom);

        if ($urandom_range(0, 49) == 0) tick_ms = tick_ms + $urandom;
        else tick_ms = tick_ms + TIME_W'($urandom_range(0, int'(shadow_hold) / 4 + 3));
        s.now_ms      = tick_ms;
        s.was_present = caller_present;
        return s;
    endfunction

    // Offers one sample and returns at the falling edge after its transaction.
    // The valid line is left high so that back-to-back samples follow directly.
    task automatic send_sample(input t_sample s);
        t_decision d;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            smp_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        smp_if.valid       <= 1'b1;
        smp_if.distance    <= s.distance;
        smp_if.zone_status <= s.zone_status;
        smp_if.now_ms      <= s.now_ms;
        smp_if.was_present <= s.was_present;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        d = qualify(s);
        pending_decisions.push_back(d);
        caller_present = d.present;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_decisions.size() != 0) @(negedge i_clk);
    endtask

    // Writes one register once the block has gone quiet.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        smp_if.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx == CFG_MAX_DISTANCE) shadow_max_dist = data;
        else if (idx == CFG_HOLD_TIME) shadow_hold = data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Default registers: a zero ring reads as stuck, then a full hold in each direction,
    // with the distance exactly at the limit counting towards absence.
    task automatic test_reset_state();
        send_sample(mk(16'd0, STATUS_VALID, 32'd0, 1'b0));
        send_sample(mk(16'd500, STATUS_VALID, 32'd100, 1'b0));
        send_sample(mk(16'd500, STATUS_VALID, 32'd2100, 1'b0));
        send_sample(mk(16'd1000, STATUS_SIGMA_BAD, 32'd2200, 1'b1));
        send_sample(mk(16'hFFFF, STATUS_NO_TARGET, 32'hFFFF_FFFF, 1'b1));
    endtask

    // A zero hold time fires on the very sample that arms the timer.
    task automatic test_hold_zero();
        write_reg(CFG_MAX_DISTANCE, 16'hFFFF);
        write_reg(CFG_HOLD_TIME, 16'd0);
        send_sample(mk(16'hFFFF, STATUS_VALID, 32'hFFFF_FFFF, 1'b0));
        send_sample(mk(16'hFFFF, 8'hFF, 32'd5, 1'b1));
        write_reg(CFG_MAX_DISTANCE, 16'd0);
        send_sample(mk(16'd0, STATUS_VALID, 32'd6, 1'b0));
        send_sample(mk(16'd0, STATUS_SIGMA_BAD, 32'd7, 1'b1));
    endtask

    // The elapsed time is taken modulo 2^32 across the tick wrapping round.
    task automatic test_timer_wrap();
        write_reg(CFG_MAX_DISTANCE, 16'd1000);
        write_reg(CFG_HOLD_TIME, 16'd100);
        send_sample(mk(16'd200, STATUS_VALID, 32'hFFFF_FFC0, 1'b0));
        send_sample(mk(16'd200, STATUS_VALID, 32'h0000_0030, 1'b0));
    endtask

    // Ten equal distances fill the ring: stuck blocks arrival and forces departure.
    task automatic test_stuck_ring();
        write_reg(CFG_HOLD_TIME, 16'd0);
        for (int n = 0; n < RING_DEPTH; n++) begin
            send_sample(mk(16'd500, STATUS_VALID, 32'd1000 + n, 1'b0));
        end
        send_sample(mk(16'd500, STATUS_VALID, 32'd2000, 1'b1));
    endtask

    // One random phase under a given register setting and idling pattern.
    task automatic run_phase(input logic [CFG_W-1:0] max_dist, input logic [CFG_W-1:0] hold,
                             input int idle_pct, input int stall_pct);
        write_reg(CFG_MAX_DISTANCE, max_dist);
        write_reg(CFG_HOLD_TIME, hold);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (PHASE_ITEMS) send_sample(next_sample());
    endtask

    // The receiver holds off long enough for the block to fill and stall its input;
    // later the sender pauses until every decision has come back.
    task automatic test_backpressure();
        write_reg(CFG_MAX_DISTANCE, 16'd800);
        write_reg(CFG_HOLD_TIME, 16'd40);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left  = 300;
        repeat (40) send_sample(next_sample());
        smp_if.valid <= 1'b0;
        wait_drained();
        repeat (20) send_sample(next_sample());
    endtask

    task automatic test_random_phases();
        run_phase(16'd1000, 16'd2000, 0, 0);
        run_phase(16'd0, 16'd0, 64, 0);
        run_phase(16'hFFFF, 16'hFFFF, 0, 64);
        run_phase(16'd300, 16'd50, 37, 37);
        run_phase(16'hFFFF, 16'd0, 0, 0);
        run_phase(16'd0, 16'hFFFF, 64, 0);
        run_phase(CFG_W'($urandom), CFG_W'($urandom_range(0, 500)), 0, 64);
        run_phase(CFG_W'($urandom), CFG_W'($urandom), 37, 37);
    endtask

    // Receiver: a requested hold-off first, otherwise random stalls.
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            dec_if.ready <= 1'b0;
            hold_off_left = hold_off_left - 1;
        end else begin
            dec_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Each decision transaction is compared with the oldest pending decision.
    always @(posedge i_clk) begin : check_decisions
        t_decision want;
        if (i_rst_n && dec_if.valid && dec_if.ready) begin
            if (pending_decisions.size() == 0) begin
                $display("%0t: unexpected decision present=%0b stuck=%0b", $time,
                         dec_if.present, dec_if.stuck);
                mismatch_count++;
            end else begin
                want = pending_decisions.pop_front();
                if (dec_if.present !== want.present) begin
                    $display("%0t: present expected %0b actual %0b", $time,
                             want.present, dec_if.present);
                    mismatch_count++;
                end
                if (dec_if.stuck !== want.stuck) begin
                    $display("%0t: stuck expected %0b actual %0b", $time,
                             want.stuck, dec_if.stuck);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction or write happens for too long.
    always @(posedge i_clk) begin : watchdog
        int quiet_cycles;
        if ((smp_if.valid && smp_if.ready) || (dec_if.valid && dec_if.ready) || cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[range_presence_qualifier_core] ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = CFG_MAX_DISTANCE;
        cfg_data           = '0;
        smp_if.valid       = 1'b0;
        smp_if.distance    = '0;
        smp_if.zone_status = STATUS_VALID;
        smp_if.now_ms      = '0;
        smp_if.was_present = 1'b0;
        dec_if.ready       = 1'b0;

        mismatch_count  = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_left   = 0;
        caller_present  = 1'b0;
        near_scene      = 1'b1;
        tick_ms         = 32'hFFFF_F000;
        repeat_left     = 0;
        repeat_dist     = '0;
        for (int k = 0; k < RING_DEPTH; k++) shadow_ring[k] = '0;
        shadow_slot     = '0;
        shadow_armed    = 1'b0;
        shadow_start    = '0;
        shadow_max_dist = MAX_DISTANCE_RST;
        shadow_hold     = HOLD_TIME_RST;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_hold_zero();
        test_timer_wrap();
        test_stuck_ring();
        test_backpressure();
        test_random_phases();

        // Let the last decisions drain, then give any stray one time to appear.
        smp_if.valid <= 1'b0;
        wait_drained();
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0 && pending_decisions.size() == 0) begin
            $display("[range_presence_qualifier_core] OK");
        end else begin
            $display("[range_presence_qualifier_core] ERROR");
        end
        $finish;
    end

endmodule
